@@ design/imu_sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_pkg
// Shared types and constants for the IMU serial frame decoder.
// ----------------------------------------------------------------------------
package imu_sfd_pkg;

    // Frame layout
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [3:0] POS_IDLE   = 4'd0;
    localparam logic [3:0] POS_TYPE   = 4'd1;
    localparam logic [3:0] POS_DATA0  = 4'd2;
    localparam logic [3:0] POS_LAST   = 4'd10;
    localparam int         DATA_BYTES = 6;

    // Result kinds
    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    // Q16 scale factors: full scale times 65536, rounded
    localparam logic [23:0] K_ACC   = 24'd10276045;
    localparam logic [23:0] K_GYRO  = 24'd2287638;
    localparam logic [23:0] K_ANGLE = 24'd11796480;

    // Decoded frame payload
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x_raw;
        logic signed [15:0] y_raw;
        logic signed [15:0] z_raw;
    } frame_t;

    // Parser status toward the output stage
    typedef struct packed {
        logic fire;     // good frame completes on this request
        logic at_last;  // next byte is the checksum byte
    } prs_stat_t;

    function automatic logic [23:0] scale_k(input logic [1:0] kind);
        logic [23:0] k;
        unique case (kind)
            KIND_ACC:   k = K_ACC;
            KIND_GYRO:  k = K_GYRO;
            KIND_ANGLE: k = K_ANGLE;
            default:    k = K_ACC;
        endcase
        return k;
    endfunction

endpackage

@@ design/imu_serial_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_top
// Decodes 11-byte IMU frames from a serial byte stream into raw and Q16 axes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received byte per
//   request. The block hunts for header 0x55, gathers the 11-byte frame and
//   checks the 8-bit sum of bytes 0..9 against byte 10.
//   Output channel (out_valid/out_ready) carries one request per good frame
//   of type 0x51/0x52/0x53: kind, three raw axes and three Q16 scaled axes.
//   Bad checksums and unknown types are dropped silently.
//   Throughput: one byte per cycle while in_ready is high. The result is
//   registered as the checksum byte is accepted; the checksum compare and the
//   three axis multipliers sit between the byte registers and that output
//   register.
//   Receiver stall: bytes keep flowing while a result waits; only the
//   checksum byte of the next frame is held off until the output register
//   is free.
//   Reset: asynchronous, clears the parser to header hunt and drops any
//   pending result. Frame byte storage needs no clearing.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top
    import imu_sfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         frame_kind,
    output logic signed [15:0] x_raw,
    output logic signed [15:0] y_raw,
    output logic signed [15:0] z_raw,
    output logic signed [24:0] x_scaled,
    output logic signed [24:0] y_scaled,
    output logic signed [24:0] z_scaled
);

    logic               accept;
    prs_stat_t          stat;
    frame_t             frame;
    logic signed [24:0] xs;
    logic signed [24:0] ys;
    logic signed [24:0] zs;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         kind_reg;
    logic signed [15:0] x_raw_reg;
    logic signed [15:0] y_raw_reg;
    logic signed [15:0] z_raw_reg;
    logic signed [24:0] x_scaled_reg;
    logic signed [24:0] y_scaled_reg;
    logic signed [24:0] z_scaled_reg;

    // Only the checksum byte needs a free output slot
    assign in_ready = !out_valid_reg || out_ready || !stat.at_last;
    assign accept   = in_valid && in_ready;

    imu_sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .stat    (stat),
        .frame   (frame)
    );

    imu_sfd_scale u_scale_x (.kind(frame.kind), .raw(frame.x_raw), .scaled(xs));
    imu_sfd_scale u_scale_y (.kind(frame.kind), .raw(frame.y_raw), .scaled(ys));
    imu_sfd_scale u_scale_z (.kind(frame.kind), .raw(frame.z_raw), .scaled(zs));

    // Output register control
    always_comb
    begin
        priority if (stat.fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (stat.fire)
        begin
            kind_reg     <= frame.kind;
            x_raw_reg    <= frame.x_raw;
            y_raw_reg    <= frame.y_raw;
            z_raw_reg    <= frame.z_raw;
            x_scaled_reg <= xs;
            y_scaled_reg <= ys;
            z_scaled_reg <= zs;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = kind_reg;
    assign x_raw      = x_raw_reg;
    assign y_raw      = y_raw_reg;
    assign z_raw      = z_raw_reg;
    assign x_scaled   = x_scaled_reg;
    assign y_scaled   = y_scaled_reg;
    assign z_scaled   = z_scaled_reg;

    // A new result never lands on one that is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !stat.fire)
        else $error("result overwritten while stalled");

    // Results only come from the checksum byte
    a_fire_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire |-> accept && stat.at_last)
        else $error("result outside checksum byte");

    // Only the three known kinds are emitted
    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == KIND_ACC || kind_reg == KIND_GYRO
                           || kind_reg == KIND_ANGLE))
        else $error("unknown frame kind emitted");

    // Scaling keeps the sign of the raw count (checked on the x axis)
    a_sign_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (x_scaled_reg[24] == x_raw_reg[15]))
        else $error("x scaling sign mismatch");

endmodule

@@ design/imu_sfd_parser.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_parser
// Header hunt, byte collection and checksum check for 11-byte frames.
// ----------------------------------------------------------------------------
module imu_sfd_parser
    import imu_sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output prs_stat_t  stat,
    output frame_t     frame
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] type_reg;
    logic [7:0] data_reg [DATA_BYTES];
    logic       type_ok;
    logic [1:0] kind;

    // Position and running sum
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (pos_reg == POS_IDLE)
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    pos_next = POS_TYPE;
                    sum_next = rx_byte;
                end
            end
            else if (pos_reg == POS_LAST)
            begin
                pos_next = POS_IDLE;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                sum_next = sum_reg + rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_IDLE;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Frame byte storage (type byte and six data bytes)
    always_ff @(posedge clk)
    begin
        if (accept && pos_reg == POS_TYPE)
        begin
            type_reg <= rx_byte;
        end
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            if (accept && pos_reg == POS_DATA0 + 4'(i))
            begin
                data_reg[i] <= rx_byte;
            end
        end
    end

    // Type decode
    always_comb
    begin
        type_ok = 1'b1;
        kind    = KIND_ACC;
        unique case (type_reg)
            TYPE_ACC:   kind = KIND_ACC;
            TYPE_GYRO:  kind = KIND_GYRO;
            TYPE_ANGLE: kind = KIND_ANGLE;
            default:    type_ok = 1'b0;
        endcase
    end

    assign stat.at_last = (pos_reg == POS_LAST);
    assign stat.fire    = accept && stat.at_last && (sum_reg == rx_byte) && type_ok;

    // Little-endian axis values
    assign frame.kind  = kind;
    assign frame.x_raw = signed'({data_reg[1], data_reg[0]});
    assign frame.y_raw = signed'({data_reg[3], data_reg[2]});
    assign frame.z_raw = signed'({data_reg[5], data_reg[4]});

endmodule

@@ design/imu_sfd_scale.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_scale
// One axis lane: raw count times kind constant, arithmetic shift right by 15.
// ----------------------------------------------------------------------------
module imu_sfd_scale
    import imu_sfd_pkg::*;
(
    input  logic [1:0]         kind,
    input  logic signed [15:0] raw,
    output logic signed [24:0] scaled
);

    logic signed [24:0] k_s;
    logic signed [40:0] prod;

    // |prod| < 2^39, so bits 39..15 hold the floored Q16 value
    assign k_s    = signed'({1'b0, scale_k(kind)});
    assign prod   = 41'(raw) * 41'(k_s);
    assign scaled = prod[39:15];

endmodule
